>>> rtl/core/bbt_pkg.sv
// Shared types and constants for the Bollinger band tracker.
`timescale 1ns / 1ps
`default_nettype none
package bbt_pkg;
    localparam int WindowMaxDefault  = 64;
    localparam int SampleBitsDefault = 24;
    localparam int LenBits           = 7;
    localparam int CoefBits          = 12;
    localparam int MeanBits          = 24;
    localparam int SdBits            = 24;
    localparam int UpperBits         = 28;
    localparam int LowerBits         = 29;
    localparam logic [LenBits-1:0]  LenReset  = 7'd20;
    localparam logic [CoefBits-1:0] CoefReset = 12'd512;
    localparam logic CfgIdxLen  = 1'b0;
    localparam logic CfgIdxCoef = 1'b1;

    // Controller commands to the datapath.
    typedef struct packed {
        logic load;      // read old entry, latch sample
        logic update;    // write ring, update sums
        logic prep;      // form variance radicand
        logic div_start; // start mean divide
        logic div_step;  // one divide step
        logic sd_start;  // start sd divide
        logic sq_step;   // one square root step
        logic band;      // compute bands
        logic restart;   // clear history
    } bbt_cmd_t;

    typedef struct packed {
        logic div_done;
        logic sq_done;
    } bbt_sts_t;
endpackage
`default_nettype wire

>>> rtl/core/bbt_datapath.sv
// Datapath: sample ring, running sums, serial divider and square root, bands.
`timescale 1ns / 1ps
`default_nettype none
module bbt_datapath #(
    parameter int WINDOW_MAX  = bbt_pkg::WindowMaxDefault,
    parameter int SAMPLE_BITS = bbt_pkg::SampleBitsDefault
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bbt_pkg::bbt_cmd_t             cmd,
    output bbt_pkg::bbt_sts_t                  sts,
    input  wire logic [SAMPLE_BITS-1:0]        sample,
    input  wire logic [bbt_pkg::LenBits-1:0]   len_cfg,
    input  wire logic [bbt_pkg::CoefBits-1:0]  coef,
    output logic                               full,
    output logic [bbt_pkg::MeanBits-1:0]       mean_out,
    output logic [bbt_pkg::SdBits-1:0]         sd_out,
    output logic [bbt_pkg::UpperBits-1:0]      upper_out,
    output logic signed [bbt_pkg::LowerBits-1:0] lower_out
);
    localparam int PosBits = $clog2(WINDOW_MAX);
    localparam int CntBits = $clog2(WINDOW_MAX + 1);
    localparam int SumBits = SAMPLE_BITS + CntBits;
    localparam int SqBits  = 2 * SAMPLE_BITS + CntBits;
    localparam int RadBits = SqBits + CntBits;       // N*sumsq
    localparam int RootBits = (RadBits + 1) / 2;
    localparam int LoopBits = $clog2(RootBits + SumBits + 1);
    localparam int MeanW = bbt_pkg::MeanBits;
    localparam int OffBits = bbt_pkg::CoefBits + RootBits;

    // Effective window length, clamped to 1..WINDOW_MAX
    logic [CntBits-1:0] n_eff;
    always_comb
    begin
        priority if (len_cfg == '0)
            n_eff = CntBits'(1);
        else if (32'(len_cfg) > 32'(WINDOW_MAX))
            n_eff = CntBits'(WINDOW_MAX);
        else
            n_eff = CntBits'(len_cfg);
    end

    logic [SAMPLE_BITS-1:0] ring [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] old_reg;
    logic [SAMPLE_BITS-1:0] x_reg;
    logic [PosBits-1:0]     pos_reg, pos_next;
    logic [CntBits-1:0]     seen_reg, seen_next;
    logic [SumBits-1:0]     sum_reg, sum_next;
    logic [SqBits-1:0]      sq_reg, sq_next;
    logic                   evict_reg;
    logic [PosBits-1:0]     wpos;

    assign wpos = (CntBits'(pos_reg) >= n_eff) ? '0 : pos_reg;

    // Ring memory: read old entry on load, write new one on update
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            old_reg <= ring[wpos];
        if (cmd.update)
            ring[wpos] <= x_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg     <= sample;
            evict_reg <= (seen_reg >= n_eff);
        end
    end

    // Running state update
    logic [SqBits-1:0] x_sq, old_sq;
    logic [PosBits:0]  pos_inc;
    assign x_sq    = SqBits'(x_reg) * SqBits'(x_reg);
    assign old_sq  = SqBits'(old_reg) * SqBits'(old_reg);
    assign pos_inc = {1'b0, wpos} + 1'b1;
    always_comb
    begin
        pos_next  = pos_reg;
        seen_next = seen_reg;
        sum_next  = sum_reg;
        sq_next   = sq_reg;
        if (cmd.restart)
        begin
            pos_next  = '0;
            seen_next = '0;
            sum_next  = '0;
            sq_next   = '0;
        end
        else if (cmd.update)
        begin
            if (evict_reg)
            begin
                sum_next = sum_reg - SumBits'(old_reg) + SumBits'(x_reg);
                sq_next  = sq_reg - old_sq + x_sq;
            end
            else
            begin
                seen_next = seen_reg + 1'b1;
                sum_next  = sum_reg + SumBits'(x_reg);
                sq_next   = sq_reg + x_sq;
            end
            pos_next = (CntBits'(pos_inc) >= n_eff) ? '0 : pos_inc[PosBits-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            seen_reg <= '0;
            sum_reg  <= '0;
            sq_reg   <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            seen_reg <= seen_next;
            sum_reg  <= sum_next;
            sq_reg   <= sq_next;
        end
    end

    // Radicand N*sumsq - sum^2 (one multiply per product)
    logic [RadBits-1:0] scaled, sumsq2, rad_reg;
    assign scaled = RadBits'(sq_reg) * RadBits'(n_eff);
    assign sumsq2 = RadBits'(sum_reg) * RadBits'(sum_reg);

    // Restoring square root, one bit a cycle
    logic [RootBits-1:0] root_reg;
    logic [LoopBits-1:0] bit_reg;
    logic [RadBits+1:0]  rem_reg, trial;
    logic [RadBits+1:0]  rem_sh;
    logic [RadBits-1:0]  rad_sh;
    assign rem_sh = {rem_reg[RadBits-1:0], rad_reg[RadBits-1 -: 2]};
    assign trial  = rem_sh - (RadBits + 2)'({root_reg, 2'b01});
    assign rad_sh = {rad_reg[RadBits-3:0], 2'b00};

    // Restoring divider for mean and sd, one bit a cycle
    logic [SumBits-1:0]  quo_reg;
    logic [CntBits:0]    drem_reg;
    logic [CntBits:0]    dtry;
    logic [SumBits-1:0]  q_sh;
    assign dtry = {drem_reg[CntBits-1:0], quo_reg[SumBits-1]} - {1'b0, n_eff};
    assign q_sh = {quo_reg[SumBits-2:0], 1'b0};

    logic [MeanW-1:0] mean_reg;
    logic [OffBits-1:0] off;
    assign off = (OffBits'(coef) * OffBits'(quo_reg)) >> 8;

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            rad_reg  <= (sumsq2 <= scaled) ? (scaled - sumsq2) : '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.sq_step)
        begin
            rad_reg <= rad_sh;
            if (!trial[RadBits+1])
            begin
                rem_reg  <= trial;
                root_reg <= {root_reg[RootBits-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[RootBits-2:0], 1'b0};
            end
        end
        if (cmd.div_start)
        begin
            quo_reg  <= sum_reg;
            drem_reg <= '0;
        end
        else if (cmd.sd_start)
        begin
            mean_reg <= MeanW'(quo_reg);
            quo_reg  <= SumBits'(root_reg);
            drem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!dtry[CntBits])
            begin
                drem_reg <= dtry;
                quo_reg  <= q_sh | SumBits'(1);
            end
            else
            begin
                drem_reg <= {drem_reg[CntBits-1:0], quo_reg[SumBits-1]};
                quo_reg  <= q_sh;
            end
        end
        if (cmd.band)
        begin
            full      <= (seen_reg >= n_eff);
            mean_out  <= (seen_reg >= n_eff) ? mean_reg : '0;
            sd_out    <= (seen_reg >= n_eff) ? MeanW'(quo_reg) : '0;
            upper_out <= (seen_reg >= n_eff)
                ? bbt_pkg::UpperBits'(OffBits'(mean_reg) + off) : '0;
            lower_out <= (seen_reg >= n_eff)
                ? bbt_pkg::LowerBits'(OffBits'(mean_reg) - off) : '0;
        end
    end

    // Step counters for the serial units
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bit_reg <= '0;
        else if (cmd.prep || cmd.div_start || cmd.sd_start)
            bit_reg <= '0;
        else if (cmd.sq_step || cmd.div_step)
            bit_reg <= bit_reg + 1'b1;
    end
    assign sts.sq_done  = (32'(bit_reg) == 32'(RootBits - 1));
    assign sts.div_done = (32'(bit_reg) == 32'(SumBits - 1));
endmodule
`default_nettype wire

>>> rtl/core/bbt_ctrl.sv
// Controller: sequences load, update, mean divide, square root, sd divide, bands.
`timescale 1ns / 1ps
`default_nettype none
module bbt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_fire,
    input  wire logic              out_fire,
    input  wire logic              restart,
    input  wire bbt_pkg::bbt_sts_t sts,
    output bbt_pkg::bbt_cmd_t      cmd,
    output logic                   in_rdy,
    output logic                   out_vld
);
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_LOAD  = 9'b000000010,
        S_UPD   = 9'b000000100,
        S_MDIV  = 9'b000001000,
        S_SQ    = 9'b000010000,
        S_SDIV  = 9'b000100000,
        S_BAND  = 9'b001000000,
        S_PREP  = 9'b010000000,
        S_SDST  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   ovld_reg, ovld_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_fire) state_next = S_LOAD;
            S_LOAD: state_next = S_UPD;
            S_UPD:  state_next = S_MDIV;
            S_MDIV: if (sts.div_done) state_next = S_PREP;
            S_PREP: state_next = S_SQ;
            S_SQ:   if (sts.sq_done) state_next = S_SDST;
            S_SDST: state_next = S_SDIV;
            S_SDIV: if (sts.div_done) state_next = S_BAND;
            S_BAND: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Hold the result until the transaction completes
    always_comb
    begin
        ovld_next = ovld_reg;
        if (out_fire)
            ovld_next = 1'b0;
        if (state_reg == S_BAND)
            ovld_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ovld_reg  <= ovld_next;
        end
    end

    // Input waits until the previous result has been delivered
    assign in_rdy  = (state_reg == S_IDLE) && !ovld_reg;
    assign out_vld = ovld_reg;

    always_comb
    begin
        cmd           = '0;
        cmd.load      = in_fire;
        cmd.update    = (state_reg == S_LOAD);
        cmd.div_start = (state_reg == S_UPD);
        cmd.div_step  = (state_reg == S_MDIV) || (state_reg == S_SDIV);
        cmd.prep      = (state_reg == S_PREP);
        cmd.sq_step   = (state_reg == S_SQ);
        cmd.sd_start  = (state_reg == S_SDST);
        cmd.band      = (state_reg == S_BAND) && !out_fire ? 1'b1 : (state_reg == S_BAND);
        cmd.restart   = restart;
    end
endmodule
`default_nettype wire

>>> rtl/core/bollinger_band_tracker_core.sv
// Top level of the Bollinger band tracker.
`timescale 1ns / 1ps
`default_nettype none
// One price sample per transaction; one result per sample. Each sample makes
// two runs of the bit-serial divider (mean, then sd) and one of the bit-serial
// square root. W = SAMPLE_BITS + clog2(WINDOW_MAX+1) is the step count of each
// divider run and R = (2*SAMPLE_BITS + 2*clog2(WINDOW_MAX+1) + 1)/2 the step
// count of the square root. A new sample is taken only once the previous result
// has been delivered, so a receiver stall also holds off the next sample.
// Writing window_length restarts history.
module bollinger_band_tracker_core #(
    parameter int WINDOW_MAX  = bbt_pkg::WindowMaxDefault,
    parameter int SAMPLE_BITS = bbt_pkg::SampleBitsDefault
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [23:0] price_sample,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             window_full,
    output logic [23:0]      moving_mean,
    output logic [23:0]      std_deviation,
    output logic [27:0]      upper_band,
    output logic signed [28:0] lower_band
);
    logic [bbt_pkg::LenBits-1:0]  len_reg;
    logic [bbt_pkg::CoefBits-1:0] coef_reg;
    logic cfg_fire, in_fire, out_fire, restart;
    bbt_pkg::bbt_cmd_t cmd;
    bbt_pkg::bbt_sts_t sts;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    assign restart   = cfg_fire && (cfg_index == bbt_pkg::CfgIdxLen);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= bbt_pkg::LenReset;
            coef_reg <= bbt_pkg::CoefReset;
        end
        else if (cfg_fire)
        begin
            if (cfg_index == bbt_pkg::CfgIdxLen)
                len_reg <= cfg_data[bbt_pkg::LenBits-1:0];
            else
                coef_reg <= cfg_data[bbt_pkg::CoefBits-1:0];
        end
    end

    bbt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
        .restart(restart), .sts(sts), .cmd(cmd), .in_rdy(in_ready),
        .out_vld(out_valid)
    );

    bbt_datapath #(.WINDOW_MAX(WINDOW_MAX), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .sample(SAMPLE_BITS'(price_sample)), .len_cfg(len_reg), .coef(coef_reg),
        .full(window_full), .mean_out(moving_mean), .sd_out(std_deviation),
        .upper_out(upper_band), .lower_out(lower_band)
    );
endmodule
`default_nettype wire
